@@ sv/renh_pkg.sv @@
// Shared types and constants for the ray/edge nearest-hit block.
// No dependencies.
package renh_pkg;

   localparam int COORD_W        = 32;
   localparam int OBJECT_ID_BITS = 16;
   localparam int DIFF_W         = COORD_W + 1;
   localparam int PROD_W         = 2 * DIFF_W;
   localparam int CROSS_W        = PROD_W + 1;
   localparam int MAG_W          = PROD_W;
   localparam int HALF_W         = MAG_W / 2;
   localparam int NUM_W          = MAG_W + COORD_W + 1;
   localparam int QUO_W          = COORD_W + 2;
   localparam int DIST_W         = 64;
   localparam int DIV_STEPS      = COORD_W + 1;
   localparam int STEP_W         = 6;
   localparam int REQ_DATA_W     = 8 * COORD_W + OBJECT_ID_BITS;
   localparam int RSP_DATA_W     = 2 * COORD_W + OBJECT_ID_BITS;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic {
      KIND_RAY  = 1'b0,
      KIND_EDGE = 1'b1
   } kind_type;

   typedef struct packed {
      logic                        is_ray;
      logic                        last;
      logic                        hit_ok;
      logic [MAG_W-1:0]            tn;
      logic [MAG_W-1:0]            den;
      logic signed [DIFF_W-1:0]    rx;
      logic signed [DIFF_W-1:0]    ry;
      logic [COORD_W-1:0]          org_x;
      logic [COORD_W-1:0]          org_y;
      logic [OBJECT_ID_BITS-1:0]   obj;
   } job_type;

endpackage

@@ sv/renh_front.sv @@
// Front end: accepts ray and edge items, holds the ray, runs the cross-product
// hit test and pushes a job into the queue. Depends on renh_pkg.
module renh_front import renh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  push_valid,
   input  logic                  push_ready,
   output job_type               push_job
);

   typedef enum logic [2:0] {F_IDLE, F_DIFF, F_MUL, F_CROSS, F_PUSH} fstate_type;

   fstate_type state_ff;
   logic [COORD_W-1:0] org_x_ff, org_y_ff, tgt_x_ff, tgt_y_ff;
   logic [COORD_W-1:0] cx_ff, cy_ff, dx_ff, dy_ff;
   logic [OBJECT_ID_BITS-1:0] obj_ff;
   logic last_ff;
   logic signed [DIFF_W-1:0] rx_ff, ry_ff, sx_ff, sy_ff, qx_ff, qy_ff;
   logic signed [PROD_W-1:0] p_rs1_ff, p_rs2_ff, p_qs1_ff, p_qs2_ff, p_qr1_ff, p_qr2_ff;
   job_type job_ff;

   logic signed [CROSS_W-1:0] den_s, tn_s, un_s, den_a, tn_a, un_a;
   logic hit_ok;

   always_comb begin
      den_s = CROSS_W'(p_rs1_ff) - CROSS_W'(p_rs2_ff);
      tn_s  = CROSS_W'(p_qs1_ff) - CROSS_W'(p_qs2_ff);
      un_s  = CROSS_W'(p_qr1_ff) - CROSS_W'(p_qr2_ff);
      den_a = den_s[CROSS_W-1] ? -den_s : den_s;
      tn_a  = den_s[CROSS_W-1] ? -tn_s  : tn_s;
      un_a  = den_s[CROSS_W-1] ? -un_s  : un_s;
      hit_ok = (den_s != '0)
               && !tn_a[CROSS_W-1] && (tn_a != '0) && (tn_a <= den_a)
               && !un_a[CROSS_W-1] && (un_a != '0) && (un_a <= den_a);
   end

   assign req_tready = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_job   = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         org_x_ff <= '0;
         org_y_ff <= '0;
         tgt_x_ff <= '0;
         tgt_y_ff <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_tvalid) begin
                  last_ff <= req_tlast;
                  if (req_tuser == KIND_RAY) begin
                     org_x_ff      <= req_tdata[31:0];
                     org_y_ff      <= req_tdata[63:32];
                     tgt_x_ff      <= req_tdata[95:64];
                     tgt_y_ff      <= req_tdata[127:96];
                     job_ff.is_ray <= 1'b1;
                     job_ff.last   <= req_tlast;
                     state_ff      <= F_PUSH;
                  end else begin
                     cx_ff    <= req_tdata[159:128];
                     cy_ff    <= req_tdata[191:160];
                     dx_ff    <= req_tdata[223:192];
                     dy_ff    <= req_tdata[255:224];
                     obj_ff   <= req_tdata[271:256];
                     state_ff <= F_DIFF;
                  end
               end
            end
            F_DIFF: begin
               rx_ff <= DIFF_W'(signed'(tgt_x_ff)) - DIFF_W'(signed'(org_x_ff));
               ry_ff <= DIFF_W'(signed'(tgt_y_ff)) - DIFF_W'(signed'(org_y_ff));
               sx_ff <= DIFF_W'(signed'(dx_ff)) - DIFF_W'(signed'(cx_ff));
               sy_ff <= DIFF_W'(signed'(dy_ff)) - DIFF_W'(signed'(cy_ff));
               qx_ff <= DIFF_W'(signed'(cx_ff)) - DIFF_W'(signed'(org_x_ff));
               qy_ff <= DIFF_W'(signed'(cy_ff)) - DIFF_W'(signed'(org_y_ff));
               state_ff <= F_MUL;
            end
            F_MUL: begin
               p_rs1_ff <= rx_ff * sy_ff;
               p_rs2_ff <= ry_ff * sx_ff;
               p_qs1_ff <= qx_ff * sy_ff;
               p_qs2_ff <= qy_ff * sx_ff;
               p_qr1_ff <= qx_ff * ry_ff;
               p_qr2_ff <= qy_ff * rx_ff;
               state_ff <= F_CROSS;
            end
            F_CROSS: begin
               job_ff.is_ray <= 1'b0;
               job_ff.last   <= last_ff;
               job_ff.hit_ok <= hit_ok;
               job_ff.tn     <= tn_a[MAG_W-1:0];
               job_ff.den    <= den_a[MAG_W-1:0];
               job_ff.rx     <= rx_ff;
               job_ff.ry     <= ry_ff;
               job_ff.org_x  <= org_x_ff;
               job_ff.org_y  <= org_y_ff;
               job_ff.obj    <= obj_ff;
               state_ff      <= F_PUSH;
            end
            F_PUSH: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

@@ sv/renh_queue.sv @@
// Two-entry job queue between front and back end.
// Depends on renh_pkg.
module renh_queue import renh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type mem_ff [QUEUE_DEPTH];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic do_push, do_pop;

   assign push_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

@@ sv/renh_back.sv @@
// Back end: hit point by multiply and bit-serial divide, distance compare,
// nearest-hit tracking and the result register. Depends on renh_pkg.
module renh_back import renh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  job_type               pop_job,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   typedef enum logic [3:0] {
      B_IDLE, B_MUL_LO, B_MUL_HI, B_SUM, B_DIV, B_ROUND, B_SQUARE, B_UPDATE, B_EMIT
   } bstate_type;

   bstate_type state_ff;
   job_type job_ff;
   logic axis_ff;
   logic [COORD_W-1:0] mag_ff;
   logic [HALF_W+COORD_W-1:0] plo_ff, phi_ff;
   logic [NUM_W-1:0] rem_ff, dsh_ff;
   logic [QUO_W-1:0] quo_ff, qmx_ff, qmy_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIST_W-1:0] sqx_ff, sqy_ff;
   logic found_ff;
   logic [COORD_W-1:0] best_x_ff, best_y_ff;
   logic [OBJECT_ID_BITS-1:0] best_obj_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic rsp_valid_ff, rsp_hit_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [DIFF_W-1:0] abs_ry;
   logic [QUO_W-1:0] quo_rnd;
   logic [DIST_W:0] dist_sum;
   logic [DIST_W-1:0] dist_sat;
   logic [COORD_W-1:0] ofs_x, ofs_y, px, py;
   logic take, sub_ok;

   always_comb begin
      abs_ry   = job_ff.ry[DIFF_W-1] ? DIFF_W'(-job_ff.ry) : DIFF_W'(job_ff.ry);
      sub_ok   = (dsh_ff <= rem_ff);
      quo_rnd  = quo_ff + QUO_W'(NUM_W'(job_ff.den) <= {rem_ff[NUM_W-2:0], 1'b0});
      dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      dist_sat = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
      ofs_x    = qmx_ff[COORD_W-1:0];
      ofs_y    = qmy_ff[COORD_W-1:0];
      px       = job_ff.org_x + (job_ff.rx[DIFF_W-1] ? -ofs_x : ofs_x);
      py       = job_ff.org_y + (job_ff.ry[DIFF_W-1] ? -ofs_y : ofs_y);
      take     = !found_ff || (dist_sat < best_dist_ff);
   end

   assign pop_ready  = (state_ff == B_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         found_ff     <= 1'b0;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         best_obj_ff  <= '0;
         best_dist_ff <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == B_EMIT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  job_ff <= pop_job;
                  if (pop_job.is_ray) begin
                     found_ff     <= 1'b0;
                     best_x_ff    <= '0;
                     best_y_ff    <= '0;
                     best_obj_ff  <= '0;
                     best_dist_ff <= '1;
                     state_ff     <= pop_job.last ? B_EMIT : B_IDLE;
                  end else if (pop_job.hit_ok) begin
                     axis_ff  <= 1'b0;
                     mag_ff   <= pop_job.rx[DIFF_W-1] ? COORD_W'(-pop_job.rx)
                                                      : COORD_W'(pop_job.rx);
                     state_ff <= B_MUL_LO;
                  end else begin
                     state_ff <= pop_job.last ? B_EMIT : B_IDLE;
                  end
               end
            end
            B_MUL_LO: begin
               plo_ff   <= job_ff.tn[HALF_W-1:0] * mag_ff;
               state_ff <= B_MUL_HI;
            end
            B_MUL_HI: begin
               phi_ff   <= job_ff.tn[MAG_W-1:HALF_W] * mag_ff;
               state_ff <= B_SUM;
            end
            B_SUM: begin
               rem_ff   <= NUM_W'(plo_ff) + (NUM_W'(phi_ff) << HALF_W);
               dsh_ff   <= NUM_W'(job_ff.den) << COORD_W;
               quo_ff   <= '0;
               step_ff  <= '0;
               state_ff <= B_DIV;
            end
            B_DIV: begin
               if (sub_ok) begin
                  rem_ff <= rem_ff - dsh_ff;
               end
               quo_ff  <= {quo_ff[QUO_W-2:0], sub_ok};
               dsh_ff  <= dsh_ff >> 1;
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  state_ff <= B_ROUND;
               end
            end
            B_ROUND: begin
               if (!axis_ff) begin
                  qmx_ff   <= quo_rnd;
                  axis_ff  <= 1'b1;
                  mag_ff   <= abs_ry[COORD_W-1:0];
                  state_ff <= B_MUL_LO;
               end else begin
                  qmy_ff   <= quo_rnd;
                  state_ff <= B_SQUARE;
               end
            end
            B_SQUARE: begin
               sqx_ff   <= DIST_W'(qmx_ff[COORD_W-1:0]) * DIST_W'(qmx_ff[COORD_W-1:0]);
               sqy_ff   <= DIST_W'(qmy_ff[COORD_W-1:0]) * DIST_W'(qmy_ff[COORD_W-1:0]);
               state_ff <= B_UPDATE;
            end
            B_UPDATE: begin
               if (take) begin
                  found_ff     <= 1'b1;
                  best_dist_ff <= dist_sat;
                  best_x_ff    <= px;
                  best_y_ff    <= py;
                  best_obj_ff  <= job_ff.obj;
               end
               state_ff <= job_ff.last ? B_EMIT : B_IDLE;
            end
            B_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_hit_ff   <= found_ff;
                  rsp_data_ff  <= found_ff ? {best_obj_ff, best_y_ff, best_x_ff} : '0;
                  found_ff     <= 1'b0;
                  best_x_ff    <= '0;
                  best_y_ff    <= '0;
                  best_obj_ff  <= '0;
                  best_dist_ff <= '1;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

@@ sv/ray_edge_nearest_hit.sv @@
// Top level of the ray/edge nearest-hit block.
// Depends on renh_pkg, renh_front, renh_queue, renh_back.
//
// A ray item (tuser 0) loads ray start and end and clears the running best;
// each edge item (tuser 1) is intersected with the ray by exact cross products
// and the nearest hit is kept, earlier wins on ties. The item with tlast set
// yields one result: tuser = hit, tdata = point and object, zeros on a miss.
// An edge item passes front states F_DIFF, F_MUL, F_CROSS, F_PUSH, a ray item
// only F_PUSH; a hit edge then runs the back end's multiply, the bit-serial
// divider once per axis (33 steps each), squaring and update; a missed edge or
// a ray only B_IDLE. An item with tlast adds B_EMIT to emit the result. A
// two-entry queue lets the front test further edges while the back works.
module ray_edge_nearest_hit import renh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // ray_start_x, ray_start_y, ray_end_x, ray_end_y,
   // edge_start_x, edge_start_y, edge_end_x, edge_end_y, object_id
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit_x, hit_y, hit_object
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // hit
   output logic                  rsp_tuser
);

   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_job, pop_job;

   renh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   renh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   renh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ bench/ray_edge_nearest_hit_tb.sv @@
// Testbench for ray_edge_nearest_hit: drives ray and edge items with random gaps,
// predicts the nearest hit with exact wide arithmetic and checks every result item.
// Depends on renh_pkg and the ray_edge_nearest_hit RTL.
`timescale 1ns / 1ps

module ray_edge_nearest_hit_tb;
   import renh_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TARGET_ITEMS   = 450;

   typedef struct {
      logic                      hit;
      logic [COORD_W-1:0]        x;
      logic [COORD_W-1:0]        y;
      logic [OBJECT_ID_BITS-1:0] obj;
   } hit_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   hit_result_type expected_hits[$];
   int          errors = 0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;
   int          rsp_stall = 0;

   // predictor state
   logic signed [31:0]        ray_ax = 0, ray_ay = 0, ray_bx = 0, ray_by = 0;
   logic                      near_found = 0;
   logic [31:0]               near_x = 0, near_y = 0;
   logic [OBJECT_ID_BITS-1:0] near_obj = 0;
   logic [63:0]               near_dist = '1;

   ray_edge_nearest_hit uut (.*);

   always #1 clock = ~clock;

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic clear_nearest();
      near_found = 0;
      near_x = 0;
      near_y = 0;
      near_obj = 0;
      near_dist = '1;
   endtask

   function automatic logic signed [127:0] rounded_offset(logic signed [127:0] comp,
         logic signed [127:0] tn, logic signed [127:0] den);
      logic signed [127:0] mag, num, q, r;
      mag = comp < 0 ? -comp : comp;
      num = tn * mag;
      q = num / den;
      r = num % den;
      if (2 * r >= den) q = q + 1;
      return comp < 0 ? -q : q;
   endfunction

   task automatic intersect_edge(logic signed [31:0] cx, logic signed [31:0] cy,
         logic signed [31:0] dx, logic signed [31:0] dy, logic [15:0] obj);
      logic signed [127:0] rx, ry, sx, sy, qx, qy, den, tn, un, ox, oy, sq;
      logic [63:0] a2, b2, cand_dist;
      rx = ray_bx; rx = rx - ray_ax;
      ry = ray_by; ry = ry - ray_ay;
      sx = dx; sx = sx - cx;
      sy = dy; sy = sy - cy;
      qx = cx; qx = qx - ray_ax;
      qy = cy; qy = qy - ray_ay;
      den = rx * sy - ry * sx;
      tn = qx * sy - qy * sx;
      un = qx * ry - qy * rx;
      if (den == 0) return;
      if (den < 0) begin
         den = -den;
         tn = -tn;
         un = -un;
      end
      if (tn <= 0 || tn > den || un <= 0 || un > den) return;
      ox = rounded_offset(rx, tn, den);
      oy = rounded_offset(ry, tn, den);
      sq = ox * ox;
      a2 = sq[63:0];
      sq = oy * oy;
      b2 = sq[63:0];
      cand_dist = a2 + b2;
      if (cand_dist < a2) cand_dist = '1;
      if (!near_found || cand_dist < near_dist) begin
         near_found = 1;
         near_dist = cand_dist;
         near_x = ray_ax + ox[31:0];
         near_y = ray_ay + oy[31:0];
         near_obj = obj[OBJECT_ID_BITS-1:0];
      end
   endtask

   task automatic predict_item(kind_type kind, logic [REQ_DATA_W-1:0] data, logic last);
      hit_result_type res;
      if (kind == KIND_RAY) begin
         ray_ax = data[31:0];
         ray_ay = data[63:32];
         ray_bx = data[95:64];
         ray_by = data[127:96];
         clear_nearest();
      end else begin
         intersect_edge(data[159:128], data[191:160], data[223:192], data[255:224],
                        data[271:256]);
      end
      if (last) begin
         res.hit = near_found;
         res.x = near_x;
         res.y = near_y;
         res.obj = near_obj;
         expected_hits = {expected_hits, res};
         clear_nearest();
      end
   endtask

   task automatic send_item(kind_type kind, logic [REQ_DATA_W-1:0] data, logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= kind;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_item(kind, data, last);
      items_sent++;
   endtask

   function automatic logic [REQ_DATA_W-1:0] filler();
      logic [REQ_DATA_W-1:0] v;
      for (int i = 0; i < REQ_DATA_W / 32 + 1; i++) v = REQ_DATA_W'({v, $urandom()});
      return v;
   endfunction

   task automatic send_ray(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
         logic [31:0] by, logic last);
      logic [REQ_DATA_W-1:0] d;
      d = filler();
      d[127:0] = {by, bx, ay, ax};
      send_item(KIND_RAY, d, last);
   endtask

   task automatic send_edge(logic [31:0] cx, logic [31:0] cy, logic [31:0] dx,
         logic [31:0] dy, logic [15:0] obj, logic last);
      logic [REQ_DATA_W-1:0] d;
      d = filler();
      d[271:128] = {obj, dy, dx, cy, cx};
      send_item(KIND_EDGE, d, last);
   endtask

   function automatic logic [31:0] q16(int v);
      return v <<< 16;
   endfunction

   task automatic test_edge_before_ray();
      send_edge(q16(-5), q16(0), q16(5), q16(0), 16'h0001, 1);
      send_ray(q16(1), q16(1), q16(1), q16(1), 0);
      send_edge(q16(0), q16(0), q16(2), q16(2), 16'h0002, 1);
   endtask

   task automatic test_ray_last();
      send_ray(q16(0), q16(0), q16(10), q16(0), 1);
   endtask

   task automatic test_vertical_and_parallel();
      send_ray(q16(3), q16(-4), q16(3), q16(9), 0);
      send_edge(q16(3), q16(0), q16(3), q16(5), 16'h0010, 0);
      send_edge(q16(1), q16(2), q16(8), q16(2), 16'h0011, 0);
      send_edge(q16(0), q16(1), q16(7), q16(1), 16'h0012, 1);
   endtask

   task automatic test_bounds();
      send_ray(q16(0), q16(0), q16(10), q16(0), 0);
      send_edge(q16(10), q16(-1), q16(10), q16(1), 16'h0020, 0);
      send_edge(q16(0), q16(-1), q16(0), q16(1), 16'h0021, 0);
      send_edge(q16(6), q16(-3), q16(6), q16(0), 16'h0022, 0);
      send_edge(q16(7), q16(0), q16(7), q16(3), 16'h0023, 0);
      send_edge(q16(11), q16(-1), q16(11), q16(1), 16'h0024, 1);
   endtask

   task automatic test_ties();
      send_ray(q16(0), q16(0), q16(10), q16(0), 0);
      send_edge(q16(5), q16(-1), q16(5), q16(1), 16'h0031, 0);
      send_edge(q16(5), q16(2), q16(5), q16(-2), 16'h0032, 0);
      send_edge(q16(8), q16(-1), q16(8), q16(1), 16'h0033, 0);
      send_edge(q16(3), q16(-1), q16(3), q16(1), 16'h0034, 1);
   endtask

   task automatic test_extremes();
      send_ray(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_edge(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 16'hffff, 1);
      send_ray(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0);
      send_edge(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0000, 0);
      send_edge(32'h0000_0001, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 16'h8000, 1);
   endtask

   function automatic logic [31:0] rand_coord(int span);
      if (span == 0) return $urandom();
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic test_random();
      int span, n, pick;
      logic [31:0] ax, ay, bx, by, px, py, cx, cy;
      while (items_sent < TARGET_ITEMS) begin
         quiet = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 9);
         span = pick == 0 ? 0 : (pick < 4 ? 1 << 12 : 1 << 22);
         ax = rand_coord(span); ay = rand_coord(span);
         bx = rand_coord(span); by = rand_coord(span);
         if ($urandom_range(0, 15) == 0) begin bx = ax; by = ay; end
         n = $urandom_range(0, 8);
         send_ray(ax, ay, bx, by, n == 0);
         for (int i = 1; i <= n; i++) begin
            if ($urandom_range(0, 3) != 0) begin
               // edge built around a point on the ray so that most of them cross it
               px = ax + ($signed(bx - ax) >>> $urandom_range(0, 3));
               py = ay + ($signed(by - ay) >>> $urandom_range(0, 3));
               cx = px + rand_coord(span == 0 ? 1 << 24 : span);
               cy = py + rand_coord(span == 0 ? 1 << 24 : span);
               send_edge(cx, cy, 2 * px - cx + $urandom_range(0, 7),
                         2 * py - cy + $urandom_range(0, 7), 16'($urandom()), i == n);
            end else begin
               send_edge(rand_coord(span), rand_coord(span), rand_coord(span),
                         rand_coord(span), 16'($urandom()), i == n);
            end
         end
      end
      quiet = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         int stall;
         hit_result_type want;
         if (expected_hits.size() == 0) begin
            report("unexpected result", rsp_tdata[63:0], 64'd0);
         end else begin
            want = expected_hits.pop_front();
            if (rsp_tuser !== want.hit) report("hit", rsp_tuser, want.hit);
            if (rsp_tdata[31:0] !== want.x) report("hit_x", rsp_tdata[31:0], want.x);
            if (rsp_tdata[63:32] !== want.y) report("hit_y", rsp_tdata[63:32], want.y);
            if (rsp_tdata[79:64] !== want.obj) report("hit_object", rsp_tdata[79:64], want.obj);
         end
         stall = quiet ? 0 : $urandom_range(0, 19);
         rsp_stall <= stall;
         rsp_tready <= (stall == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_edge_before_ray();
      test_ray_last();
      test_vertical_and_parallel();
      test_bounds();
      test_ties();
      test_extremes();
      test_random();
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/renh_pkg.sv
sv/renh_front.sv
sv/renh_queue.sv
sv/renh_back.sv
sv/ray_edge_nearest_hit.sv
bench/ray_edge_nearest_hit_tb.sv
